// File: hdl/lsmc_pkg.sv
// Shared types and constants for the line substring match counter.
// No dependencies; imported by lsmc_matcher and line_substring_match_counter_unit.
package lsmc_pkg;

    // Fixed field widths
    localparam int BYTE_W       = 8;
    localparam int LEN_W        = 5;
    localparam int COUNT_W      = 32;
    localparam int PAT_W        = 128;
    localparam int CFG_DATA_W   = 64;
    localparam int CFG_IDX_W    = 2;
    localparam int IN_DATA_W    = 8;
    localparam int OUT_DATA_W   = 104;

    localparam int DEF_MAX_PATTERN_BYTES = 16;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PAT_LOW  = 2'd0,
        CFG_PAT_HIGH = 2'd1,
        CFG_PAT_LEN  = 2'd2,
        CFG_REVERSE  = 2'd3
    } cfg_idx_t;

    // Search setup handed to the matcher
    typedef struct packed {
        logic [PAT_W-1:0] pattern;
        logic [LEN_W-1:0] length;
        logic             reverse;
    } cfg_t;

    // Saturating increment of a counter
    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
        logic [COUNT_W-1:0] r;
        r = (v == COUNT_MAX) ? v : v + COUNT_W'(1);
        return r;
    endfunction

endpackage

// File: hdl/lsmc_matcher.sv
// Parallel window compare: checks the newest bytes of a line against the pattern.
// Depends on lsmc_pkg for the setup struct and field widths.
module lsmc_matcher #(
    parameter int MAX_PATTERN_BYTES = lsmc_pkg::DEF_MAX_PATTERN_BYTES,
    parameter int CNT_W             = $clog2(MAX_PATTERN_BYTES + 1)
) (
    input  logic [MAX_PATTERN_BYTES*8-1:0] window,     // byte 0 is the newest
    input  logic [CNT_W-1:0]               fill,       // bytes seen in the line
    input  lsmc_pkg::cfg_t                 cfg,
    output logic                           hit
);
    import lsmc_pkg::*;

    logic [LEN_W-1:0]  len_m1;
    logic              len_ok;
    logic [MAX_PATTERN_BYTES-1:0] byte_ok;

    assign len_m1 = cfg.length - LEN_W'(1);
    assign len_ok = (cfg.length != '0)
                 && (cfg.length <= LEN_W'(MAX_PATTERN_BYTES))
                 && (LEN_W'(fill) >= cfg.length);

    // Compare every window position; positions past the length always pass
    always_comb
    begin
        logic [LEN_W-1:0] idx;
        logic [3:0]       k;
        for (int d = 0; d < MAX_PATTERN_BYTES; d++)
        begin
            idx = len_m1 - LEN_W'(d);
            k   = cfg.reverse ? 4'(d) : idx[3:0];
            if (LEN_W'(d) < cfg.length)
            begin
                byte_ok[d] = (window[d*8 +: 8] == cfg.pattern[k*8 +: 8]);
            end
            else
            begin
                byte_ok[d] = 1'b1;
            end
        end
    end

    assign hit = len_ok && (&byte_ok);

endmodule

// File: hdl/line_substring_match_counter_unit.sv
// Top level of the line substring match counter: stream ports, search state, counters.
// Depends on lsmc_pkg and lsmc_matcher.
//
// Usage: text bytes enter on the s_axis channel, one byte per transaction; a
// transaction with s_axis_tlast high closes the current line and its byte is
// ignored. Every input transaction yields exactly one result transaction on
// m_axis: a flag for an occurrence ending at this byte, a flag for a matched
// line on line end, and the occurrence, matched-line and line-number counts.
// The pattern (up to MAX_PATTERN_BYTES bytes), its length and the reverse flag
// are written through cfg_we/cfg_index/cfg_data while the stream is idle.
// A result is registered: the input register captures the byte, then the result
// register takes its result once the previous result is taken. Throughput: one
// transaction per cycle while m_axis_tready is high, set by the combinational window
// compare and counter update between the two registers.
// Reset clears the window, line state and counters (line number starts at 1)
// and the configuration. When m_axis_tready is low the result register holds,
// the input register fills, and s_axis_tready then drops until the result
// is taken; nothing is lost or repeated.
module line_substring_match_counter_unit #(
    parameter int MAX_PATTERN_BYTES = lsmc_pkg::DEF_MAX_PATTERN_BYTES
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration write port
    input  logic                                cfg_we,
    input  logic [lsmc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [lsmc_pkg::CFG_DATA_W-1:0]     cfg_data,
    // text input stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [lsmc_pkg::IN_DATA_W-1:0]      s_axis_tdata,  // [7:0] text_byte
    input  logic                                s_axis_tlast,  // line_end
    // result stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [0] match_here, [1] line_matched, [33:2] occurrence_total,
    // [65:34] matched_line_total, [97:66] line_number, [103:98] zero
    output logic [lsmc_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);
    import lsmc_pkg::*;

    localparam int WIN_W = MAX_PATTERN_BYTES * BYTE_W;
    localparam int CNT_W = $clog2(MAX_PATTERN_BYTES + 1);

    // configuration
    cfg_t cfg_reg;

    // input register
    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_last_reg;

    // search state
    logic [WIN_W-1:0]   win_reg,  win_next, win_shift;
    logic [CNT_W-1:0]   fill_reg, fill_next, fill_inc;
    logic [LEN_W-1:0]   hold_reg, hold_next;
    logic               line_hit_reg, line_hit_next;
    logic [COUNT_W-1:0] occ_reg, occ_next;
    logic [COUNT_W-1:0] mline_reg, mline_next;
    logic [COUNT_W-1:0] line_reg, line_next;

    // result register
    logic               out_valid_reg;
    logic               out_match_reg, out_match_next;
    logic               out_lm_reg, out_lm_next;
    logic [COUNT_W-1:0] out_line_reg;

    logic advance;
    logic hit;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_PAT_LOW:  cfg_reg.pattern[63:0]   <= cfg_data;
                CFG_PAT_HIGH: cfg_reg.pattern[127:64] <= cfg_data;
                CFG_PAT_LEN:  cfg_reg.length          <= cfg_data[LEN_W-1:0];
                CFG_REVERSE:  cfg_reg.reverse         <= cfg_data[0];
            endcase
        end
    end

    // Capture the input transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_byte_reg <= s_axis_tdata[BYTE_W-1:0];
            in_last_reg <= s_axis_tlast;
        end
    end

    // Shift the new byte into the window
    always_comb
    begin
        win_shift = win_reg;
        for (int i = MAX_PATTERN_BYTES - 1; i > 0; i--)
        begin
            win_shift[i*BYTE_W +: BYTE_W] = win_reg[(i-1)*BYTE_W +: BYTE_W];
        end
        win_shift[BYTE_W-1:0] = in_byte_reg;
    end

    assign fill_inc = (fill_reg == CNT_W'(MAX_PATTERN_BYTES)) ? fill_reg
                                                              : fill_reg + CNT_W'(1);

    lsmc_matcher #(
        .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES),
        .CNT_W             (CNT_W)
    ) u_matcher (
        .window (win_shift),
        .fill   (fill_inc),
        .cfg    (cfg_reg),
        .hit    (hit)
    );

    // Next search state and counters for the item in the input register
    always_comb
    begin
        win_next       = win_reg;
        fill_next      = fill_reg;
        hold_next      = hold_reg;
        line_hit_next  = line_hit_reg;
        occ_next       = occ_reg;
        mline_next     = mline_reg;
        line_next      = line_reg;
        out_match_next = 1'b0;
        out_lm_next    = 1'b0;
        if (in_last_reg)
        begin
            out_lm_next   = line_hit_reg;
            win_next      = '0;
            fill_next     = '0;
            hold_next     = '0;
            line_hit_next = 1'b0;
            line_next     = sat_inc(line_reg);
        end
        else
        begin
            win_next  = win_shift;
            fill_next = fill_inc;
            if (hold_reg != '0)
            begin
                hold_next = hold_reg - LEN_W'(1);
            end
            else if (hit)
            begin
                out_match_next = 1'b1;
                hold_next      = cfg_reg.length - LEN_W'(1);
                if (!line_hit_reg)
                begin
                    mline_next = sat_inc(mline_reg);
                end
                line_hit_next  = 1'b1;
                occ_next       = sat_inc(occ_reg);
            end
        end
    end

    // Advance the search state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg      <= '0;
            fill_reg     <= '0;
            hold_reg     <= '0;
            line_hit_reg <= 1'b0;
            occ_reg      <= '0;
            mline_reg    <= '0;
            line_reg     <= COUNT_W'(1);
        end
        else if (advance)
        begin
            win_reg      <= win_next;
            fill_reg     <= fill_next;
            hold_reg     <= hold_next;
            line_hit_reg <= line_hit_next;
            occ_reg      <= occ_next;
            mline_reg    <= mline_next;
            line_reg     <= line_next;
        end
    end

    // Result register: hold while the receiver stalls
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_match_reg <= out_match_next;
            out_lm_reg    <= out_lm_next;
            out_line_reg  <= line_reg;
        end
    end

    // Counts after the step equal the state registers, which only move on advance
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'b0, out_line_reg, mline_reg, occ_reg, out_lm_reg, out_match_reg};

    // A line end leaves a clean line behind
    a_line_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_last_reg |=> !line_hit_reg && fill_reg == '0 && hold_reg == '0)
        else $error("line state not cleared at line end");

    // The holdoff never reaches the pattern capacity
    a_hold_bound: assert property (@(posedge clk) disable iff (!rst_n)
        hold_reg < LEN_W'(MAX_PATTERN_BYTES))
        else $error("overlap holdoff out of range");

    // No occurrence is reported while bytes are blocked by the previous one
    a_hold_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        advance && hold_reg != '0 |=> !out_match_reg)
        else $error("match reported during holdoff");

    // Occurrence count never falls
    a_occ_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> occ_reg >= $past(occ_reg))
        else $error("occurrence count decreased");

    // A reported occurrence marks the line as matched
    a_match_marks_line: assert property (@(posedge clk) disable iff (!rst_n)
        advance && out_match_next |=> line_hit_reg)
        else $error("match without line flag");

endmodule

// File: dv/tb_line_substring_match_counter_unit.sv
// Self-checking testbench for line_substring_match_counter_unit: text stream in, one result per byte.
// A tracker class predicts every result from its own copy of the search state and configuration.
// Depends on lsmc_pkg and the unit's RTL only.
module tb_line_substring_match_counter_unit;
    import lsmc_pkg::*;

    localparam int MAX_PAT      = DEF_MAX_PATTERN_BYTES;
    localparam int TEXT_ITEMS   = 1100;
    localparam int LONG_HOLD    = 250;
    localparam int REPORT_LIMIT = 10;

    // One result transaction, field by field
    typedef struct packed {
        logic               match_here;
        logic               line_matched;
        logic [COUNT_W-1:0] occurrence_total;
        logic [COUNT_W-1:0] matched_line_total;
        logic [COUNT_W-1:0] line_number;
    } search_result_t;

    // Predicts the result of each accepted text transaction and checks the outputs
    class search_tracker;
        logic [PAT_W-1:0]   pattern;
        logic [LEN_W-1:0]   pat_len;
        logic               reversed;
        logic [BYTE_W-1:0]  window [MAX_PAT];
        logic [LEN_W-1:0]   fill;
        logic [LEN_W-1:0]   holdoff;
        logic               line_hit;
        logic [COUNT_W-1:0] occurrences;
        logic [COUNT_W-1:0] hit_lines;
        logic [COUNT_W-1:0] line_no;
        search_result_t     awaited [$];
        int                 failures;

        function new();
            pattern     = '0;
            pat_len     = '0;
            reversed    = 1'b0;
            clear_line();
            occurrences = '0;
            hit_lines   = '0;
            line_no     = COUNT_W'(1);
            failures    = 0;
        endfunction

        function void clear_line();
            foreach (window[k])
                window[k] = '0;
            fill     = '0;
            holdoff  = '0;
            line_hit = 1'b0;
        endfunction

        function void set_register(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_PAT_LOW:  pattern[CFG_DATA_W-1:0]     = val;
                CFG_PAT_HIGH: pattern[PAT_W-1:CFG_DATA_W] = val;
                CFG_PAT_LEN:  pat_len                     = val[LEN_W-1:0];
                CFG_REVERSE:  reversed                    = val[0];
                default:      ;
            endcase
        endfunction

        function logic [COUNT_W-1:0] bump(logic [COUNT_W-1:0] v);
            return (v == COUNT_MAX) ? v : v + COUNT_W'(1);
        endfunction

        // Newest byte sits in window[0]; it must equal the last byte of the occurrence
        function bit window_hit();
            int          len;
            int          d;
            logic [7:0]  want;
            len = int'(pat_len);
            if (len == 0 || len > MAX_PAT || fill < len)
                return 1'b0;
            for (d = 0; d < len; d++)
            begin
                want = reversed ? pattern[d*8 +: 8] : pattern[(len-1-d)*8 +: 8];
                if (window[d] != want)
                    return 1'b0;
            end
            return 1'b1;
        endfunction

        function void note_input(logic [BYTE_W-1:0] ch, logic last);
            search_result_t r;
            int             k;
            r             = '0;
            r.line_number = line_no;
            if (last)
            begin
                r.line_matched = line_hit;
                clear_line();
                line_no = bump(line_no);
            end
            else
            begin
                for (k = MAX_PAT - 1; k > 0; k--)
                    window[k] = window[k-1];
                window[0] = ch;
                if (fill < MAX_PAT)
                    fill++;
                if (holdoff != 0)
                    holdoff--;
                else if (window_hit())
                begin
                    r.match_here = 1'b1;
                    holdoff      = pat_len - LEN_W'(1);
                    if (!line_hit)
                        hit_lines = bump(hit_lines);
                    line_hit    = 1'b1;
                    occurrences = bump(occurrences);
                end
            end
            r.occurrence_total   = occurrences;
            r.matched_line_total = hit_lines;
            awaited.push_back(r);
        endfunction

        function void compare(string name, logic [COUNT_W-1:0] want, logic [COUNT_W-1:0] got);
            if (want !== got)
            begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display("mismatch on %s: expected %0h, got %0h (%0d results pending)",
                             name, want, got, awaited.size());
            end
        endfunction

        function void check_result(logic [OUT_DATA_W-1:0] data);
            search_result_t want;
            search_result_t got;
            got = data[$bits(search_result_t)-1:0];
            got.match_here         = data[0];
            got.line_matched       = data[1];
            got.occurrence_total   = data[33:2];
            got.matched_line_total = data[65:34];
            got.line_number        = data[97:66];
            if (awaited.size() == 0)
            begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display("result with no prediction waiting: %h", data);
                return;
            end
            want = awaited.pop_front();
            compare("match_here", COUNT_W'(want.match_here), COUNT_W'(got.match_here));
            compare("line_matched", COUNT_W'(want.line_matched), COUNT_W'(got.line_matched));
            compare("occurrence_total", want.occurrence_total, got.occurrence_total);
            compare("matched_line_total", want.matched_line_total, got.matched_line_total);
            compare("line_number", want.line_number, got.line_number);
        endfunction
    endclass

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [CFG_DATA_W-1:0] cfg_data      = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;  // [7:0] text_byte
    logic                  s_axis_tlast  = 1'b0; // line_end
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // [0] match_here, [1] line_matched, [33:2] occurrence_total,
    // [65:34] matched_line_total, [97:66] line_number, [103:98] zero
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    search_tracker tracker = new();

    // Stimulus-side view of the current search setup
    logic [7:0] stim_pat [MAX_PAT];
    int         stim_len;
    bit         stim_rev;
    bit         narrow_alphabet;
    bit         idle_on       = 1'b1;
    int         hold_requests = 0;
    int         hold_served   = 0;
    int         hold_left     = 0;
    int         items_sent    = 0;

    line_substring_match_counter_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 clk = ~clk;

    // Note accepted text transactions first, then check accepted results
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                tracker.note_input(s_axis_tdata, s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready)
                tracker.check_result(m_axis_tdata);
        end
    end

    // Result side: random stalls, plus a long hold-off whenever one is requested
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else if (hold_served != hold_requests)
        begin
            hold_served = hold_requests;
            hold_left   = LONG_HOLD;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= !(idle_on && $urandom_range(99) < 13);
    end

    // Offer one text transaction, with an occasional one-cycle gap ahead of it
    task automatic push_text(input logic [7:0] ch, input logic last);
        if (idle_on && $urandom_range(99) < 13)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= ch;
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic wait_drained();
        do
            @(posedge clk);
        while (tracker.awaited.size() != 0);
    endtask

    // Write all four registers back to back; upper data bits carry noise
    task automatic load_search_setup(input int len, input bit rev);
        cfg_idx_t              regs [4];
        logic [CFG_DATA_W-1:0] vals [4];
        logic [CFG_DATA_W-1:0] noise;
        int                    i;
        regs  = '{CFG_PAT_LOW, CFG_PAT_HIGH, CFG_PAT_LEN, CFG_REVERSE};
        noise = {$urandom, $urandom};
        for (i = 0; i < 8; i++)
        begin
            vals[CFG_PAT_LOW][i*8 +: 8]  = stim_pat[i];
            vals[CFG_PAT_HIGH][i*8 +: 8] = stim_pat[i+8];
        end
        vals[CFG_PAT_LEN] = {noise[CFG_DATA_W-1:LEN_W], LEN_W'(len)};
        vals[CFG_REVERSE] = {noise[CFG_DATA_W-1:1], rev};
        stim_len = len;
        stim_rev = rev;
        cfg_we <= 1'b1;
        for (i = 0; i < 4; i++)
        begin
            cfg_index <= regs[i];
            cfg_data  <= vals[regs[i]];
            @(posedge clk);
            tracker.set_register(regs[i], vals[regs[i]]);
        end
        cfg_we <= 1'b0;
    endtask

    function automatic int usable_len();
        return (stim_len >= 1 && stim_len <= MAX_PAT) ? stim_len : $urandom_range(1, MAX_PAT);
    endfunction

    // Send the first count bytes of the pattern in the order that matches
    task automatic push_pattern_run(input int n, input int count);
        int i;
        for (i = 0; i < count; i++)
            push_text(stim_rev ? stim_pat[n-1-i] : stim_pat[i], 1'b0);
    endtask

    function automatic logic [7:0] filler_byte();
        if (narrow_alphabet || $urandom_range(99) < 40)
            return stim_pat[$urandom_range(usable_len() - 1)];
        return 8'($urandom);
    endfunction

    // Lines mixing whole occurrences, near misses and noise; may stop mid-line
    task automatic text_phase(input int budget);
        int line_len;
        int roll;
        int n;
        int count;
        line_len = 0;
        while (budget > 0)
        begin
            roll = $urandom_range(99);
            if (roll < 8 || line_len > 40)
            begin
                push_text(8'($urandom), 1'b1);
                line_len = 0;
                budget--;
            end
            else if (roll < 55)
            begin
                n     = usable_len();
                count = (roll < 40) ? n : $urandom_range(1, n);
                push_pattern_run(n, count);
                line_len += count;
                budget   -= count;
            end
            else
            begin
                push_text(filler_byte(), 1'b0);
                line_len++;
                budget--;
            end
        end
        s_axis_tvalid <= 1'b0;
    endtask

    // Pick pattern bytes: all zero, all ones, a two-letter alphabet or anything
    task automatic choose_pattern();
        int         kind;
        logic [7:0] a;
        logic [7:0] b;
        kind            = $urandom_range(5);
        a               = 8'($urandom);
        b               = 8'($urandom);
        narrow_alphabet = (kind == 2 || kind == 3);
        foreach (stim_pat[k])
            case (kind)
                0:       stim_pat[k] = 8'h00;
                1:       stim_pat[k] = 8'hFF;
                2, 3:    stim_pat[k] = $urandom_range(1) ? a : b;
                default: stim_pat[k] = 8'($urandom);
            endcase
    endtask

    initial
    begin
        int phase;
        int len;
        int start;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset setup has zero length: nothing matches, even zero bytes
        push_text(8'h00, 1'b0);
        push_text(8'hFF, 1'b0);
        push_text(8'h00, 1'b0);
        push_text(8'hFF, 1'b1);
        s_axis_tvalid <= 1'b0;
        wait_drained();

        // Zero pattern of three: no match before three bytes, then non-overlapping
        foreach (stim_pat[k])
            stim_pat[k] = 8'h00;
        load_search_setup(3, 1'b0);
        repeat (7) push_text(8'h00, 1'b0);
        push_text(8'h00, 1'b1);
        s_axis_tvalid <= 1'b0;
        wait_drained();

        // Reversed order: "cba" matches pattern "abc", "abc" itself does not
        stim_pat[0] = "a";
        stim_pat[1] = "b";
        stim_pat[2] = "c";
        load_search_setup(3, 1'b1);
        push_pattern_run(3, 3);
        push_text("a", 1'b0);
        push_text("b", 1'b0);
        push_text("c", 1'b0);
        push_text(8'h5A, 1'b1);
        s_axis_tvalid <= 1'b0;
        wait_drained();

        // Length above the maximum never matches
        foreach (stim_pat[k])
            stim_pat[k] = 8'h00;
        load_search_setup(MAX_PAT + 1, 1'b0);
        repeat (4) push_text(8'h00, 1'b0);
        push_text(8'h00, 1'b1);
        s_axis_tvalid <= 1'b0;
        wait_drained();

        // Random phases, each with a fresh setup written while the unit is idle
        start = items_sent;
        phase = 0;
        while (items_sent - start < TEXT_ITEMS)
        begin
            choose_pattern();
            case ($urandom_range(9))
                0:       len = 0;
                1:       len = MAX_PAT;
                2:       len = $urandom_range(MAX_PAT + 1, 31);
                3:       len = 1;
                4, 5:    len = $urandom_range(2, 4);
                default: len = $urandom_range(1, MAX_PAT);
            endcase
            load_search_setup(len, $urandom_range(1));
            idle_on = (phase != 4);
            if (phase == 2 || phase % 7 == 5)
                hold_requests++;
            text_phase($urandom_range(40, 140));
            wait_drained();
            phase++;
        end

        wait_drained();
        repeat (10) @(posedge clk);
        if (tracker.failures == 0 && tracker.awaited.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Hard stop well beyond the slowest correct run
    initial
    begin
        #1_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
